// ===== design/glb_pkg.sv =====
`default_nettype none

package glb_pkg;

   // Fixed field widths
   localparam int SAMPLE_WIDTH     = 16;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int WEIGHT_WIDTH     = WEIGHT_FRAC_BITS + 1;
   localparam int TAPS             = 5;
   localparam int CENTER_TAP       = TAPS / 2;

   // Arithmetic widths of the filter datapath
   localparam int PAIR_WIDTH = SAMPLE_WIDTH + 1;
   localparam int PROD_WIDTH = PAIR_WIDTH + WEIGHT_WIDTH + 1;
   localparam int ACC_WIDTH  = PROD_WIDTH + 2;

   // Result counter: up to three results per item
   localparam int PEND_WIDTH = 2;
   localparam int SEEN_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH = 2;

   // Register reset values
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_OUTER_RESET  = WEIGHT_WIDTH'(3571);
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_INNER_RESET  = WEIGHT_WIDTH'(16004);
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_CENTER_RESET = WEIGHT_WIDTH'(26386);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WEIGHT_OUTER  = 2'd0,
      CSR_WEIGHT_INNER  = 2'd1,
      CSR_WEIGHT_CENTER = 2'd2
   } glb_csr_type;

   typedef logic signed [SAMPLE_WIDTH-1:0] glb_sample_type;
   typedef glb_sample_type [TAPS-1:0] glb_taps_type;

   typedef struct packed {
      logic [WEIGHT_WIDTH-1:0] outer;
      logic [WEIGHT_WIDTH-1:0] inner;
      logic [WEIGHT_WIDTH-1:0] center;
   } glb_weights_type;

   // One filter job: five taps, oldest in slot 0, and the line end mark
   typedef struct packed {
      glb_taps_type taps;
      logic         done;
   } glb_job_type;

endpackage

`default_nettype wire

// ===== design/gaussian_line_blur_5tap.sv =====
// Datapath: a result passes from the tap line through the product, sum and output
// registers; the first result of a line of three or more voxels follows its
// third voxel (two samples behind), and the drained line end results follow one
// per cycle unless rsp_stall backs up the pipeline. Throughput: one voxel per
// cycle while req_stall is low; the marked last voxel yields up to three results
// issued to the single filter pipeline, so req_stall holds while they drain.
// Reset: synchronous; clears the line state and pipeline, weights load defaults.
`default_nettype none

module gaussian_line_blur_5tap
   import glb_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [WEIGHT_WIDTH-1:0]     csr_wdata,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                        req_line_end,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_blurred,
   output logic                             rsp_line_done
);

   // Weight registers
   glb_weights_type weights_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff.outer  <= WEIGHT_OUTER_RESET;
         weights_ff.inner  <= WEIGHT_INNER_RESET;
         weights_ff.center <= WEIGHT_CENTER_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WEIGHT_OUTER:  weights_ff.outer  <= csr_wdata;
            CSR_WEIGHT_INNER:  weights_ff.inner  <= csr_wdata;
            CSR_WEIGHT_CENTER: weights_ff.center <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Line state: tap line, voxels seen, results still to issue
   glb_taps_type          tap_ff, tap_in;
   logic [SEEN_WIDTH-1:0] seen_ff, seen_in;
   logic [PEND_WIDTH-1:0] pend_ff, pend_in;
   logic                  last_ff, last_in;
   logic                  accept, launch, job_ready;
   glb_job_type           job;

   assign launch    = (pend_ff != '0) && job_ready;
   assign req_stall = !((pend_ff == '0) || ((pend_ff == PEND_WIDTH'(1)) && launch));
   assign accept    = req_valid && !req_stall;

   assign job.taps = tap_ff;
   assign job.done = last_ff && (pend_ff == PEND_WIDTH'(1));

   always_comb begin
      tap_in  = tap_ff;
      seen_in = seen_ff;
      pend_in = pend_ff;
      last_in = last_ff;
      if (accept) begin
         // load the tap line for the first job of this item
         if (seen_ff == '0) begin
            for (int k = 0; k < TAPS; k++) tap_in[k] = req_sample;
         end else if (seen_ff == SEEN_WIDTH'(1) && req_line_end) begin
            // two-voxel line: start at the first right-edge window
            for (int k = 0; k < TAPS-2; k++) tap_in[k] = tap_ff[k+2];
            tap_in[TAPS-2] = req_sample;
            tap_in[TAPS-1] = req_sample;
         end else begin
            for (int k = 0; k < TAPS-1; k++) tap_in[k] = tap_ff[k+1];
            tap_in[TAPS-1] = req_sample;
         end
         // number of results caused by this item
         if (req_line_end) begin
            if (seen_ff >= SEEN_WIDTH'(2))      pend_in = PEND_WIDTH'(3);
            else if (seen_ff == SEEN_WIDTH'(1)) pend_in = PEND_WIDTH'(2);
            else                                pend_in = PEND_WIDTH'(1);
            seen_in = '0;
         end else begin
            pend_in = (seen_ff >= SEEN_WIDTH'(2)) ? PEND_WIDTH'(1) : '0;
            if (seen_ff != SEEN_WIDTH'(3)) seen_in = seen_ff + SEEN_WIDTH'(1);
         end
         last_in = req_line_end;
      end else if (launch) begin
         pend_in = pend_ff - PEND_WIDTH'(1);
         // draining the line end: repeat the last voxel
         if (pend_ff > PEND_WIDTH'(1)) begin
            for (int k = 0; k < TAPS-1; k++) tap_in[k] = tap_ff[k+1];
            tap_in[TAPS-1] = tap_ff[TAPS-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         pend_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         pend_ff <= pend_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end

   glb_filter u_filter (
      .clock         (clock),
      .reset         (reset),
      .weights       (weights_ff),
      .job_valid     (pend_ff != '0),
      .job           (job),
      .job_ready     (job_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_blurred   (rsp_blurred),
      .rsp_line_done (rsp_line_done)
   );

   // A voxel inside a line causes at most one result
   a_inner_one_result: assert property (@(posedge clock) disable iff (reset)
      accept && !req_line_end |=> pend_ff <= PEND_WIDTH'(1))
      else $error("inner voxel scheduled more than one result");

   // The line end mark closes the line
   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_line_end |=> seen_ff == '0 && last_ff)
      else $error("line state not restarted after line end");

   // The marked job is the last one of its item
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      launch && job.done && !accept |=> pend_ff == '0)
      else $error("results pending after the line end result");

endmodule

`default_nettype wire

// ===== design/glb_filter.sv =====
`default_nettype none

module glb_filter
   import glb_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire glb_weights_type          weights,
   input  wire logic                     job_valid,
   input  wire glb_job_type              job,
   output logic                          job_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_blurred,
   output logic                          rsp_line_done
);

   localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
      {{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] SAT_LO =
      {{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [ACC_WIDTH-1:0] TRUNC_BIAS =
      {{(ACC_WIDTH-WEIGHT_FRAC_BITS){1'b0}}, {WEIGHT_FRAC_BITS{1'b1}}};

   // Stage advance, back to front
   logic adv3, adv2, adv1;
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;

   assign adv3      = !rsp_valid_ff || !rsp_stall;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign job_ready = adv1;

   // Stage 1: symmetric pair sums and the three products
   logic signed [PAIR_WIDTH-1:0] outer_pair, inner_pair;
   logic signed [PROD_WIDTH-1:0] prod_outer_in, prod_inner_in, prod_center_in;
   logic signed [PROD_WIDTH-1:0] prod_outer_ff, prod_inner_ff, prod_center_ff;
   logic                         s1_done_ff;

   always_comb begin
      outer_pair = PAIR_WIDTH'($signed(job.taps[0])) + PAIR_WIDTH'($signed(job.taps[4]));
      inner_pair = PAIR_WIDTH'($signed(job.taps[1])) + PAIR_WIDTH'($signed(job.taps[3]));
      prod_outer_in  = PROD_WIDTH'(outer_pair * $signed({1'b0, weights.outer}));
      prod_inner_in  = PROD_WIDTH'(inner_pair * $signed({1'b0, weights.inner}));
      prod_center_in = PROD_WIDTH'($signed(job.taps[CENTER_TAP])
                                   * $signed({1'b0, weights.center}));
   end

   // Stage 2: full-precision sum
   logic signed [ACC_WIDTH-1:0] acc_in, acc_ff;
   logic                        s2_done_ff;

   assign acc_in = ACC_WIDTH'(prod_outer_ff) + ACC_WIDTH'(prod_inner_ff)
                 + ACC_WIDTH'(prod_center_ff);

   // Stage 3: truncate toward zero, then saturate
   logic signed [ACC_WIDTH-1:0]    biased, quot;
   logic signed [SAMPLE_WIDTH-1:0] blurred_in, blurred_ff;
   logic                           done_ff;

   always_comb begin
      biased = acc_ff[ACC_WIDTH-1] ? (acc_ff + TRUNC_BIAS) : acc_ff;
      quot   = biased >>> WEIGHT_FRAC_BITS;
      priority if (quot > SAT_HI) begin
         blurred_in = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (quot < SAT_LO) begin
         blurred_in = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         blurred_in = quot[SAMPLE_WIDTH-1:0];
      end
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff  <= job_valid;
         if (adv2) s2_valid_ff  <= s1_valid_ff;
         if (adv3) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv1 && job_valid) begin
         prod_outer_ff  <= prod_outer_in;
         prod_inner_ff  <= prod_inner_in;
         prod_center_ff <= prod_center_in;
         s1_done_ff     <= job.done;
      end
      if (adv2 && s1_valid_ff) begin
         acc_ff     <= acc_in;
         s2_done_ff <= s1_done_ff;
      end
      if (adv3 && s2_valid_ff) begin
         blurred_ff <= blurred_in;
         done_ff    <= s2_done_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blurred   = blurred_ff;
   assign rsp_line_done = done_ff;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import glb_pkg::*;

   // Run control
   localparam int DRAIN_CYCLES   = 8;     // output latency plus the drain stall
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam int IDLE_PERCENT   = 19;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [WEIGHT_WIDTH-1:0]    WEIGHT_MAX   = '1;
   localparam logic [WEIGHT_WIDTH-1:0]    WEIGHT_UNITY = WEIGHT_WIDTH'(65536);
   localparam glb_sample_type SAMPLE_MAX = 16'sh7FFF;
   localparam glb_sample_type SAMPLE_MIN = 16'sh8000;
   localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   typedef struct packed {
      glb_sample_type sample;
      logic           line_end;
   } voxel_item_t;

   typedef struct packed {
      glb_sample_type blurred;
      logic           done;
   } blur_result_t;

   // DUT ports
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [WEIGHT_WIDTH-1:0]    csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   glb_sample_type             req_sample = '0;
   logic                       req_line_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   glb_sample_type             rsp_blurred;
   logic                       rsp_line_done;

   // Stimulus and scoreboard state
   voxel_item_t  pending_voxels[$];
   blur_result_t expected_blur_q[$];
   bit           idle_on = 1'b1;
   int           voxels_accepted = 0;
   int           results_checked = 0;
   int           mismatches = 0;
   int           lines_queued = 0;
   int           weight_sets = 1;
   int           quiet_cycles = 0;

   // Shadow of the line filter
   logic [WEIGHT_WIDTH-1:0] wt_outer  = WEIGHT_OUTER_RESET;
   logic [WEIGHT_WIDTH-1:0] wt_inner  = WEIGHT_INNER_RESET;
   logic [WEIGHT_WIDTH-1:0] wt_center = WEIGHT_CENTER_RESET;
   longint                  line_win[4] = '{0, 0, 0, 0};
   int                      line_seen = 0;

   gaussian_line_blur_5tap DUT (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_line_end  (req_line_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_blurred   (rsp_blurred),
      .rsp_line_done (rsp_line_done)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Kernel on five taps, full precision, truncate toward zero, saturate
   function automatic glb_sample_type blur_kernel(longint a0, longint a1, longint a2,
                                                  longint a3, longint a4);
      longint w_o;
      longint w_i;
      longint w_c;
      longint acc;
      longint q;
      w_o = longint'(wt_outer);
      w_i = longint'(wt_inner);
      w_c = longint'(wt_center);
      acc = w_o * (a0 + a4) + w_i * (a1 + a3) + w_c * a2;
      q = acc / (longint'(1) <<< WEIGHT_FRAC_BITS);
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      return glb_sample_type'(q);
   endfunction

   function automatic void expect_blur(glb_sample_type value, logic done);
      blur_result_t r;
      r.blurred = value;
      r.done = done;
      expected_blur_q.push_back(r);
   endfunction

   // One accepted voxel: queue the results it drains, then shift the window
   function automatic void predict_voxel(glb_sample_type sample, logic last);
      longint c;
      c = sample;
      if (line_seen == 0)
         for (int i = 0; i < 4; i++) line_win[i] = c;
      if (line_seen >= 2)
         expect_blur(blur_kernel(line_win[3], line_win[2], line_win[1], line_win[0], c), 1'b0);
      if (last) begin
         if (line_seen >= 1)
            expect_blur(blur_kernel(line_win[2], line_win[1], line_win[0], c, c), 1'b0);
         expect_blur(blur_kernel(line_win[1], line_win[0], c, c, c), 1'b1);
         line_seen = 0;
      end else if (line_seen < 3) begin
         line_seen++;
      end
      line_win[3] = line_win[2];
      line_win[2] = line_win[1];
      line_win[1] = line_win[0];
      line_win[0] = c;
   endfunction

   // Driver: present the next voxel once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_voxel(req_sample, req_line_end);
            voxels_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_voxels.size() != 0 &&
                !(idle_on && $urandom_range(99) < IDLE_PERCENT)) begin
               voxel_item_t v;
               v = pending_voxels.pop_front();
               req_valid    <= 1'b1;
               req_sample   <= v.sample;
               req_line_end <= v.line_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each taken result with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_blur_q.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: unexpected result blurred=%0d line_done=%0b",
                           $realtime, rsp_blurred, rsp_line_done);
               mismatches++;
            end else begin
               blur_result_t e;
               e = expected_blur_q.pop_front();
               if (rsp_blurred !== e.blurred || rsp_line_done !== e.done) begin
                  if (mismatches < REPORT_LIMIT)
                     $display("%0t: result %0d: expected blurred=%0d line_done=%0b, got %0d %0b",
                              $realtime, results_checked, e.blurred, e.done,
                              rsp_blurred, rsp_line_done);
                  mismatches++;
               end
            end
            results_checked++;
         end
         rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Watchdog: cycles with no traffic on either channel
   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic glb_sample_type rand_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2, 3:    return glb_sample_type'($urandom_range(512) - 256);
         default: return glb_sample_type'($urandom());
      endcase
   endfunction

   function automatic int rand_line_len();
      case ($urandom_range(9))
         0:       return 1;
         1:       return 2;
         2:       return 3;
         3:       return $urandom_range(20, 40);
         default: return $urandom_range(4, 12);
      endcase
   endfunction

   function automatic void queue_voxel(glb_sample_type sample, logic last);
      voxel_item_t v;
      v.sample = sample;
      v.line_end = last;
      pending_voxels.push_back(v);
      if (last) lines_queued++;
   endfunction

   // Whole lines of random voxels until about n voxels are queued
   task automatic queue_random_lines(int n);
      int queued;
      int len;
      queued = 0;
      @(negedge clock);
      while (queued < n) begin
         len = rand_line_len();
         for (int i = 0; i < len; i++) queue_voxel(rand_sample(), i == len - 1);
         queued += len;
      end
   endtask

   // Wait until the sender is empty and every result is in, then let the pipe settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_voxels.size() != 0 || req_valid || expected_blur_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [WEIGHT_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_WEIGHT_OUTER:  wt_outer = value;
         CSR_WEIGHT_INNER:  wt_inner = value;
         CSR_WEIGHT_CENTER: wt_center = value;
         default: ;
      endcase
   endtask

   task automatic set_weights(logic [WEIGHT_WIDTH-1:0] w_o, logic [WEIGHT_WIDTH-1:0] w_i,
                              logic [WEIGHT_WIDTH-1:0] w_c);
      wait_drained();
      csr_write(CSR_WEIGHT_OUTER, w_o);
      csr_write(CSR_WEIGHT_INNER, w_i);
      csr_write(CSR_WEIGHT_CENTER, w_c);
      // unmapped index must leave the weights alone
      csr_write(CSR_UNMAPPED, WEIGHT_WIDTH'($urandom()));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      weight_sets++;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed lines at the reset weights
      @(negedge clock);
      queue_voxel(SAMPLE_MIN, 1'b1);                 // single-voxel line
      queue_voxel(SAMPLE_MAX, 1'b0);                 // two-voxel line
      queue_voxel(SAMPLE_MIN, 1'b1);
      queue_voxel(16'sd0, 1'b0);                     // three-voxel line
      queue_voxel(-16'sd1, 1'b0);
      queue_voxel(SAMPLE_MAX, 1'b1);
      queue_voxel(SAMPLE_MAX, 1'b0);
      queue_voxel(SAMPLE_MAX, 1'b0);
      queue_voxel(SAMPLE_MIN, 1'b0);
      queue_voxel(SAMPLE_MIN, 1'b0);
      queue_voxel(16'sd1, 1'b1);
      // sender holds mid-line until the block is empty
      queue_voxel(16'sh5555, 1'b0);
      queue_voxel(16'sh2AAA, 1'b0);
      queue_voxel(-16'sd100, 1'b0);
      wait_drained();
      queue_voxel(16'sd100, 1'b0);
      queue_voxel(SAMPLE_MIN, 1'b0);
      queue_voxel(SAMPLE_MAX, 1'b1);
      queue_voxel(-16'sd1, 1'b0);                    // four-voxel line
      queue_voxel(-16'sd1, 1'b0);
      queue_voxel(16'sd0, 1'b0);
      queue_voxel(16'sd0, 1'b1);

      // Long stretch with no idling on either side
      wait_drained();
      idle_on = 1'b0;
      queue_random_lines(40);
      wait_drained();
      idle_on = 1'b1;

      // Largest weights: sums saturate
      set_weights(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
      queue_random_lines(30);

      // Zero weights
      set_weights('0, '0, '0);
      queue_random_lines(20);

      // Unity on the outer taps only
      set_weights(WEIGHT_UNITY, '0, '0);
      queue_random_lines(20);

      // Unity on the center tap only: pass-through
      set_weights('0, '0, WEIGHT_UNITY);
      queue_random_lines(20);

      // Random weights over the full register width
      set_weights(WEIGHT_WIDTH'($urandom()), WEIGHT_WIDTH'($urandom()),
                  WEIGHT_WIDTH'($urandom()));
      queue_random_lines(20);

      // Back to the reset kernel
      set_weights(WEIGHT_OUTER_RESET, WEIGHT_INNER_RESET, WEIGHT_CENTER_RESET);
      queue_random_lines(25);

      wait_drained();
      $display("covered %0d voxels in %0d lines, %0d filtered results checked",
               voxels_accepted, lines_queued, results_checked);
      $display("kernel settings exercised: %0d, mismatches: %0d", weight_sets, mismatches);
      if (mismatches == 0 && expected_blur_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== gaussian_line_blur_5tap.f =====
design/glb_pkg.sv
design/glb_filter.sv
design/gaussian_line_blur_5tap.sv
tb/tb_top.sv
